[rtl/ptpr_pkg.sv]
// Shared types and constants for the planar tile pixel renderer.
// Store sizes, config register layout, command codes and the front-to-back queue item.
// No dependencies.
`timescale 1ns / 1ps

package ptpr_pkg;

	localparam int GFX_BYTES       = 32768;
	localparam int PALETTE_ENTRIES = 256;
	localparam int GFX_AW          = $clog2(GFX_BYTES);
	localparam int GFX_WAW         = GFX_AW - 1;
	localparam int GFX_WORDS       = GFX_BYTES / 2;
	localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] CMD_GFX_WR = 2'd0;
	localparam logic [1:0] CMD_PAL_WR = 2'd1;
	localparam logic [1:0] CMD_RENDER = 2'd2;

	localparam logic [1:0] CFG_TWO_BPP    = 2'd0;
	localparam logic [1:0] CFG_ZERO_TRANS = 2'd1;
	localparam logic [1:0] CFG_TILE_LIMIT = 2'd2;
	localparam logic [1:0] CFG_FILL_COLOR = 2'd3;

	localparam logic [10:0] TILE_LIMIT_RST = 11'd768;
	localparam logic [31:0] FILL_COLOR_RST = 32'hFF14141E;

	typedef struct packed {
		logic        two_bpp;
		logic        zero_transparent;
		logic [10:0] tile_limit;
		logic [31:0] fill_color;
	} cfg_t;

	typedef enum logic [1:0] {
		OP_GFX_WR,
		OP_PAL_WR,
		OP_RENDER
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [GFX_WAW-1:0] gfx_waddr;
		logic               gfx_lane;
		logic [7:0]         gfx_data;
		logic [PAL_AW-1:0]  pal_idx;
		logic [14:0]        pal_color;
		logic [GFX_WAW-1:0] tile_word;
		logic [2:0]         pal_row;
		logic               xflip;
		logic               yflip;
		logic               skip;
	} q_item_t;

endpackage

[rtl/ptpr_front.sv]
// Front end: accepts command beats, queues decoded known ones for the back end.
// Depends on ptpr_pkg.
`timescale 1ns / 1ps

module ptpr_front (
	input  logic               clk,
	input  logic               arst_n,
	input  ptpr_pkg::cfg_t     cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic [14:0]        gfx_address,
	input  logic [7:0]         gfx_byte,
	input  logic [7:0]         palette_index,
	input  logic [14:0]        palette_color,
	input  logic [15:0]        tile_entry,
	input  logic               visible,
	output logic               q_valid,
	output ptpr_pkg::q_item_t  q_item,
	input  logic               q_pop
);
	import ptpr_pkg::*;

	q_item_t               fifo_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_CW-1:0]   count_q;
	q_item_t               item;
	logic                  is_op;
	logic                  push;
	logic                  pop;
	logic [31:0]           addr32;
	logic [31:0]           tword32;
	logic [9:0]            tile;

	always_comb begin
		addr32  = 32'(gfx_address);
		tile    = tile_entry[9:0];
		tword32 = cfg.two_bpp ? (32'(tile) << 3) : (32'(tile) << 4);
		item.op        = OP_RENDER;
		item.gfx_waddr = addr32[GFX_AW-1:1];
		item.gfx_lane  = addr32[0];
		item.gfx_data  = gfx_byte;
		item.pal_idx   = palette_index[PAL_AW-1:0];
		item.pal_color = palette_color;
		item.tile_word = tword32[GFX_WAW-1:0];
		item.pal_row   = tile_entry[12:10];
		item.xflip     = tile_entry[14];
		item.yflip     = tile_entry[15];
		item.skip      = !visible || ({1'b0, tile} >= cfg.tile_limit);
		is_op          = 1'b1;
		case (cmd)
			CMD_GFX_WR: item.op = OP_GFX_WR;
			CMD_PAL_WR: item.op = OP_PAL_WR;
			CMD_RENDER: item.op = OP_RENDER;
			default:    is_op = 1'b0;
		endcase
	end

	assign in_ready = (count_q != QUEUE_CW'(QUEUE_DEPTH));
	assign push     = in_valid && in_ready && is_op;
	assign q_valid  = (count_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_item   = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= item;
		end
	end

endmodule

[rtl/ptpr_back.sv]
// Back end: graphics and palette stores, tile row sequencer and pixel pipeline.
// Depends on ptpr_pkg; fed by ptpr_front through its queue.
`timescale 1ns / 1ps

module ptpr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  ptpr_pkg::cfg_t     cfg,
	input  logic               q_valid,
	input  ptpr_pkg::q_item_t  q_item,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         pixel_x,
	output logic [2:0]         pixel_y,
	output logic [31:0]        argb,
	output logic               last
);
	import ptpr_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PRIME,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic [7:0] p0;
		logic [7:0] p1;
		logic [7:0] p2;
		logic [7:0] p3;
	} planes_t;

	localparam logic [7:0] WIDEN_LUT [32] = '{
		8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
		8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
		8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
		8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
	};

	// stores
	logic [7:0]   gfx_even_q [GFX_WORDS];
	logic [7:0]   gfx_odd_q  [GFX_WORDS];
	logic [14:0]  pal_q      [PALETTE_ENTRIES];
	planes_t      gfx_rd_q;
	logic [14:0]  pal_rd_q;

	// sequencer
	state_t              state_q;
	logic [GFX_WAW-1:0]  tw_q;
	logic [2:0]          row_q;
	logic                fx_q;
	logic                fy_q;
	logic                skip_q;
	logic [2:0]          rd_row_q;
	logic [2:0]          x_q;
	logic [2:0]          y_q;
	planes_t             plane_q;

	// pixel pipeline
	logic        valid_s1;
	logic [2:0]  x_s1;
	logic [2:0]  y_s1;
	logic        last_s1;
	logic        skip_s1;
	logic        clear_s1;
	logic        out_valid_q;
	logic [2:0]  pixel_x_q;
	logic [2:0]  pixel_y_q;
	logic [31:0] argb_q;
	logic        last_q;

	logic                take;
	logic                start;
	logic                gfx_we;
	logic                pal_we;
	logic                advance;
	logic                fire;
	logic                row_end;
	logic                gfx_re;
	logic [GFX_WAW-1:0]  rd_tw;
	logic                rd_fy;
	logic [2:0]          rd_row;
	logic [2:0]          rd_sy;
	logic [GFX_WAW-1:0]  lo_addr;
	logic [GFX_WAW-1:0]  hi_addr;
	logic [2:0]          bit_sel;
	logic [3:0]          ci;
	logic [7:0]          pi8;
	logic [PAL_AW-1:0]   pal_raddr;
	logic [31:0]         argb_d;

	assign take    = (state_q == ST_IDLE) && q_valid;
	assign q_pop   = take;
	assign start   = take && (q_item.op == OP_RENDER);
	assign gfx_we  = take && (q_item.op == OP_GFX_WR);
	assign pal_we  = take && (q_item.op == OP_PAL_WR);
	assign advance = !out_valid_q || out_ready;
	assign fire    = (state_q == ST_RUN) && advance;
	assign row_end = fire && (x_q == 3'd7);
	assign gfx_re  = start || (state_q == ST_PRIME) || row_end;

	always_comb begin
		rd_tw   = (state_q == ST_IDLE) ? q_item.tile_word : tw_q;
		rd_fy   = (state_q == ST_IDLE) ? q_item.yflip : fy_q;
		rd_row  = (state_q == ST_IDLE) ? 3'd0 : rd_row_q;
		rd_sy   = rd_fy ? ~rd_row : rd_row;
		lo_addr = rd_tw + GFX_WAW'(rd_sy);
		hi_addr = rd_tw + GFX_WAW'(rd_sy) + GFX_WAW'(8);

		bit_sel = fx_q ? x_q : ~x_q;
		ci[0]   = plane_q.p0[bit_sel];
		ci[1]   = plane_q.p1[bit_sel];
		ci[2]   = cfg.two_bpp ? 1'b0 : plane_q.p2[bit_sel];
		ci[3]   = cfg.two_bpp ? 1'b0 : plane_q.p3[bit_sel];
		pi8     = cfg.two_bpp ? {3'b000, row_q, ci[1:0]} : {1'b0, row_q, ci};
		pal_raddr = pi8[PAL_AW-1:0];

		if (skip_s1) begin
			argb_d = cfg.zero_transparent ? 32'd0 : cfg.fill_color;
		end else if (clear_s1) begin
			argb_d = 32'd0;
		end else begin
			argb_d = {8'hFF, WIDEN_LUT[pal_rd_q[4:0]], WIDEN_LUT[pal_rd_q[9:5]],
				WIDEN_LUT[pal_rd_q[14:10]]};
		end
	end

	always_ff @(posedge clk) begin
		if (gfx_we && !q_item.gfx_lane) begin
			gfx_even_q[q_item.gfx_waddr] <= q_item.gfx_data;
		end
		if (gfx_we && q_item.gfx_lane) begin
			gfx_odd_q[q_item.gfx_waddr] <= q_item.gfx_data;
		end
		if (gfx_re) begin
			gfx_rd_q.p0 <= gfx_even_q[lo_addr];
			gfx_rd_q.p1 <= gfx_odd_q[lo_addr];
			gfx_rd_q.p2 <= gfx_even_q[hi_addr];
			gfx_rd_q.p3 <= gfx_odd_q[hi_addr];
		end
		if (pal_we) begin
			pal_q[q_item.pal_idx] <= q_item.pal_color;
		end
		if (fire) begin
			pal_rd_q <= pal_q[pal_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_row_q <= '0;
			x_q      <= '0;
			y_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q  <= ST_PRIME;
						rd_row_q <= 3'd1;
					end
				end
				ST_PRIME: begin
					state_q  <= ST_RUN;
					rd_row_q <= rd_row_q + 1'b1;
					x_q      <= '0;
					y_q      <= '0;
				end
				ST_RUN: begin
					if (fire) begin
						x_q <= x_q + 1'b1;
						if (x_q == 3'd7) begin
							y_q      <= y_q + 1'b1;
							rd_row_q <= rd_row_q + 1'b1;
							if (y_q == 3'd7) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			tw_q   <= q_item.tile_word;
			row_q  <= q_item.pal_row;
			fx_q   <= q_item.xflip;
			fy_q   <= q_item.yflip;
			skip_q <= q_item.skip;
		end
		if ((state_q == ST_PRIME) || row_end) begin
			plane_q <= gfx_rd_q;
		end
		if (fire) begin
			x_s1     <= x_q;
			y_s1     <= y_q;
			last_s1  <= (x_q == 3'd7) && (y_q == 3'd7);
			skip_s1  <= skip_q;
			clear_s1 <= (ci == 4'd0) && cfg.zero_transparent;
		end
		if (advance) begin
			pixel_x_q <= x_s1;
			pixel_y_q <= y_s1;
			last_q    <= last_s1;
			argb_q    <= argb_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= fire;
			out_valid_q <= valid_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_x   = pixel_x_q;
	assign pixel_y   = pixel_y_q;
	assign argb      = argb_q;
	assign last      = last_q;

endmodule

[rtl/planar_tile_pixel_renderer_core.sv]
// Top level of the planar tile pixel renderer: config registers, front end and back end.
// Depends on ptpr_pkg, ptpr_front and ptpr_back.
//
//   channel | handshake                | payload
//   --------+--------------------------+-----------------------------------------------
//   cfg     | cfg_wen                  | cfg_index, cfg_wdata
//   in      | in_valid / in_ready      | cmd, gfx_address, gfx_byte, palette_index,
//           |                          | palette_color, tile_entry, visible
//   out     | out_valid / out_ready    | pixel_x, pixel_y, argb, last
//
// A store write lands as the back end takes it; a render issues the first row read,
// loads it in ST_PRIME, then sends 64 pixel beats, one per cycle unless output stalls,
// set by the single palette read port. The first pixel passes ST_PRIME, ST_RUN, s1 and
// the output register after the render beat is taken, and the queue register before.
// A two-entry queue lets input beats land while pixels stall; output stalls hold the pipe.
// Reset clears control and config only; both stores are undefined until written.
`timescale 1ns / 1ps

module planar_tile_pixel_renderer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [14:0] gfx_address,
	input  logic [7:0]  gfx_byte,
	input  logic [7:0]  palette_index,
	input  logic [14:0] palette_color,
	input  logic [15:0] tile_entry,
	input  logic        visible,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  pixel_x,
	output logic [2:0]  pixel_y,
	output logic [31:0] argb,
	output logic        last
);
	import ptpr_pkg::*;

	cfg_t     cfg_q;
	logic     q_valid;
	q_item_t  q_item;
	logic     q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.two_bpp          <= 1'b0;
			cfg_q.zero_transparent <= 1'b0;
			cfg_q.tile_limit       <= TILE_LIMIT_RST;
			cfg_q.fill_color       <= FILL_COLOR_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_TWO_BPP:    cfg_q.two_bpp          <= cfg_wdata[0];
				CFG_ZERO_TRANS: cfg_q.zero_transparent <= cfg_wdata[0];
				CFG_TILE_LIMIT: cfg_q.tile_limit       <= cfg_wdata[10:0];
				CFG_FILL_COLOR: cfg_q.fill_color       <= cfg_wdata;
				default:        cfg_q                  <= cfg_q;
			endcase
		end
	end

	ptpr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.gfx_address   (gfx_address),
		.gfx_byte      (gfx_byte),
		.palette_index (palette_index),
		.palette_color (palette_color),
		.tile_entry    (tile_entry),
		.visible       (visible),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop)
	);

	ptpr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.argb      (argb),
		.last      (last)
	);

endmodule

[tb/tb.sv]
// Testbench for planar_tile_pixel_renderer_core: directed table then random phases of
// store writes and tile renders; pixels are checked against predicted or fixed colours.
// Depends on ptpr_pkg and the RTL of planar_tile_pixel_renderer_core.
`timescale 1ns / 1ps

module tb;
	import ptpr_pkg::*;

	localparam logic [1:0] CMD_NOP = 2'd3;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 16;
	localparam int MAX_REPORTS    = 10;
	localparam int ITEM_BUDGET    = 250;
	localparam cfg_t RESET_CFG = '{1'b0, 1'b0, TILE_LIMIT_RST, FILL_COLOR_RST};

	typedef struct packed {
		logic [1:0]  cmd;
		logic [14:0] addr;
		logic [7:0]  gbyte;
		logic [7:0]  pidx;
		logic [14:0] pcolor;
		logic [15:0] entry;
		logic        vis;
	} beat_t;

	localparam int BEAT_W = $bits(beat_t);

	typedef struct packed {
		logic [2:0]  x;
		logic [2:0]  y;
		logic [31:0] argb;
		logic        last;
	} pixel_t;

	typedef struct {
		bit          is_cfg;
		cfg_t        cfg;
		beat_t       beat;
		bit          typed;
		logic [31:0] argb;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wen = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  cmd = '0;
	logic [14:0] gfx_address = '0;
	logic [7:0]  gfx_byte = '0;
	logic [7:0]  palette_index = '0;
	logic [14:0] palette_color = '0;
	logic [15:0] tile_entry = '0;
	logic        visible = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  pixel_x;
	logic [2:0]  pixel_y;
	logic [31:0] argb;
	logic        last;

	planar_tile_pixel_renderer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.gfx_address(gfx_address),
		.gfx_byte(gfx_byte),
		.palette_index(palette_index),
		.palette_color(palette_color),
		.tile_entry(tile_entry),
		.visible(visible),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.argb(argb),
		.last(last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	logic [7:0]  gfx_model [GFX_BYTES];
	bit          gfx_known [GFX_BYTES];
	logic [14:0] pal_model [PALETTE_ENTRIES];
	bit          pal_known [PALETTE_ENTRIES];
	cfg_t        cfg_model = RESET_CFG;
	pixel_t      pending_pixels [$];
	logic [9:0]  used_tiles [$];
	dir_row_t    dir_rows [$];
	int          mismatches = 0;
	int          quiet_cycles = 0;
	int          sent_items = 0;
	int          in_run = 0;
	int          ready_run = 0;
	int          ready_hold = 0;
	int          ready_roll;
	pixel_t      want;
	pixel_t      got;

	function automatic int stall_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int pick_gap();
		int r;
		if (in_run > 0) begin
			in_run--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			in_run = $urandom_range(20, 80);
			return 0;
		end
		if (r < 55)
			return 0;
		return stall_len();
	endfunction

	function automatic logic [7:0] widen5(logic [4:0] v);
		return 8'((int'(v) * 255) / 31);
	endfunction

	function automatic logic [31:0] to_argb(logic [14:0] c);
		return {8'hFF, widen5(c[4:0]), widen5(c[9:5]), widen5(c[14:10])};
	endfunction

	function automatic logic [14:0] tile_base(logic [9:0] t);
		return cfg_model.two_bpp ? {1'b0, t, 4'b0000} : {t, 5'b00000};
	endfunction

	function automatic beat_t noise_beat();
		beat_t b;
		b = beat_t'(BEAT_W'({$urandom, $urandom, $urandom}));
		b.cmd = CMD_NOP;
		return b;
	endfunction

	function automatic beat_t gfx_beat(logic [14:0] a, logic [7:0] d);
		beat_t b;
		b = noise_beat();
		b.cmd = CMD_GFX_WR;
		b.addr = a;
		b.gbyte = d;
		return b;
	endfunction

	function automatic beat_t pal_beat(logic [7:0] i, logic [14:0] c);
		beat_t b;
		b = noise_beat();
		b.cmd = CMD_PAL_WR;
		b.pidx = i;
		b.pcolor = c;
		return b;
	endfunction

	function automatic beat_t render_beat(logic [15:0] e, logic v);
		beat_t b;
		b = noise_beat();
		b.cmd = CMD_RENDER;
		b.entry = e;
		b.vis = v;
		return b;
	endfunction

	function automatic dir_row_t item_row(beat_t b, bit typed, logic [31:0] color);
		dir_row_t r;
		r.is_cfg = 1'b0;
		r.cfg = RESET_CFG;
		r.beat = b;
		r.typed = typed;
		r.argb = color;
		return r;
	endfunction

	function automatic dir_row_t cfg_row(cfg_t c);
		dir_row_t r;
		r = item_row(noise_beat(), 1'b0, 32'h0);
		r.is_cfg = 1'b1;
		r.cfg = c;
		return r;
	endfunction

	function automatic cfg_t pick_cfg(int phase);
		cfg_t c;
		c.two_bpp = 1'($urandom_range(0, 1));
		c.zero_transparent = 1'($urandom_range(0, 1));
		c.tile_limit = 11'($urandom_range(0, 1024));
		c.fill_color = $urandom;
		case (phase)
			0: c = '{1'b0, 1'b0, 11'd1024, 32'h0000_0000};
			1: c = '{1'b1, 1'b1, 11'd0, 32'hFFFF_FFFF};
			2: c = '{1'b0, 1'b1, 11'd1024, c.fill_color};
			3: c = '{1'b1, 1'b0, TILE_LIMIT_RST, 32'hFFFF_FFFF};
			default: begin
				if ($urandom_range(0, 3) == 0)
					c.tile_limit = 11'd1024;
			end
		endcase
		return c;
	endfunction

	function automatic void predict_tile_pixels(logic [15:0] entry, logic vis);
		logic [9:0]  tile;
		logic [2:0]  row;
		logic        skip;
		logic [31:0] skip_col;
		logic [31:0] color;
		logic [14:0] base;
		logic [14:0] a;
		logic [7:0]  p0, p1, p2, p3;
		logic [3:0]  ci;
		logic [7:0]  pidx;
		int          sy, sx, bp;
		pixel_t      px;
		tile = entry[9:0];
		row = entry[12:10];
		skip = !vis || ({1'b0, tile} >= cfg_model.tile_limit);
		skip_col = cfg_model.zero_transparent ? 32'h0 : cfg_model.fill_color;
		base = tile_base(tile);
		for (int y = 0; y < 8; y++) begin
			sy = entry[15] ? 7 - y : y;
			a = base + 15'(sy * 2);
			p0 = gfx_model[a];
			p1 = gfx_model[15'(a + 15'd1)];
			p2 = cfg_model.two_bpp ? 8'h00 : gfx_model[15'(a + 15'd16)];
			p3 = cfg_model.two_bpp ? 8'h00 : gfx_model[15'(a + 15'd17)];
			for (int x = 0; x < 8; x++) begin
				sx = entry[14] ? 7 - x : x;
				bp = 7 - sx;
				ci = {p3[bp], p2[bp], p1[bp], p0[bp]};
				if (skip) begin
					color = skip_col;
				end else if (ci == 4'd0 && cfg_model.zero_transparent) begin
					color = 32'h0;
				end else begin
					pidx = cfg_model.two_bpp ? 8'(int'(row) * 4 + int'(ci))
						: 8'(int'(row) * 16 + int'(ci));
					color = to_argb(pal_model[pidx]);
				end
				px.x = 3'(x);
				px.y = 3'(y);
				px.argb = color;
				px.last = (x == 7 && y == 7);
				pending_pixels.push_back(px);
			end
		end
	endfunction

	task automatic send_beat(beat_t b, bit typed, logic [31:0] color);
		int gap;
		pixel_t px;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= b.cmd;
		gfx_address <= b.addr;
		gfx_byte <= b.gbyte;
		palette_index <= b.pidx;
		palette_color <= b.pcolor;
		tile_entry <= b.entry;
		visible <= b.vis;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent_items++;
		case (b.cmd)
			CMD_GFX_WR: begin
				gfx_model[b.addr] = b.gbyte;
				gfx_known[b.addr] = 1'b1;
			end
			CMD_PAL_WR: begin
				pal_model[b.pidx] = b.pcolor;
				pal_known[b.pidx] = 1'b1;
			end
			CMD_RENDER: begin
				if (typed) begin
					for (int k = 0; k < 64; k++) begin
						px.x = 3'(k % 8);
						px.y = 3'(k / 8);
						px.argb = color;
						px.last = (k == 63);
						pending_pixels.push_back(px);
					end
				end else begin
					predict_tile_pixels(b.entry, b.vis);
				end
			end
			default: ;
		endcase
	endtask

	// every byte the render reads has been written; palette rows only when it looks them up
	task automatic prepare_tile(logic [15:0] entry, logic vis, bit random_fill);
		logic [14:0] base;
		logic [14:0] a;
		logic [7:0]  pi;
		logic        skip;
		int          nbytes, ncolors;
		nbytes = cfg_model.two_bpp ? 16 : 32;
		ncolors = cfg_model.two_bpp ? 4 : 16;
		base = tile_base(entry[9:0]);
		skip = !vis || ({1'b0, entry[9:0]} >= cfg_model.tile_limit);
		for (int i = 0; i < nbytes; i++) begin
			a = base + 15'(i);
			if (!gfx_known[a])
				send_beat(gfx_beat(a, random_fill ? 8'($urandom) : 8'h00), 1'b0, 32'h0);
		end
		if (!skip) begin
			for (int i = 0; i < ncolors; i++) begin
				pi = 8'(int'(entry[12:10]) * ncolors + i);
				if (!pal_known[pi])
					send_beat(pal_beat(pi, random_fill ? 15'($urandom) : 15'h0000), 1'b0,
						32'h0);
			end
		end
		if (used_tiles.size() < 48)
			used_tiles.push_back(entry[9:0]);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_pixels.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic apply_cfg(cfg_t c);
		write_reg(CFG_TWO_BPP, {31'b0, c.two_bpp});
		write_reg(CFG_ZERO_TRANS, {31'b0, c.zero_transparent});
		write_reg(CFG_TILE_LIMIT, {21'b0, c.tile_limit});
		write_reg(CFG_FILL_COLOR, c.fill_color);
		cfg_wen <= 1'b0;
		cfg_model = c;
	endtask

	// output side: random stalls, with occasional long stretches of steady ready
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (ready_run > 0) begin
			ready_run = ready_run - 1;
			out_ready <= 1'b1;
		end else if (ready_hold > 0) begin
			ready_hold = ready_hold - 1;
			out_ready <= 1'b0;
		end else begin
			ready_roll = $urandom_range(0, 99);
			if (ready_roll < 3) begin
				ready_run = $urandom_range(30, 150);
				out_ready <= 1'b1;
			end else if (ready_roll < 60) begin
				out_ready <= 1'b1;
			end else begin
				ready_hold = stall_len() - 1;
				out_ready <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got = {pixel_x, pixel_y, argb, last};
			if (pending_pixels.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("unexpected pixel beat: x=%0d y=%0d argb=%08h last=%0b",
						pixel_x, pixel_y, argb, last);
				mismatches++;
			end else begin
				want = pending_pixels.pop_front();
				if (got !== want) begin
					if (mismatches < MAX_REPORTS)
						$display("mismatch: exp %0d,%0d %08h %0b got %0d,%0d %08h %0b",
							want.x, want.y, want.argb, want.last,
							got.x, got.y, got.argb, got.last);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		int          phase;
		int          burst;
		int          roll;
		logic [15:0] entry;
		logic        vis;
		logic [14:0] addr;

		dir_rows.push_back(item_row(noise_beat(), 1'b0, 32'h0));
		dir_rows.push_back(item_row(render_beat(16'hFFFF, 1'b0), 1'b1, FILL_COLOR_RST));
		dir_rows.push_back(item_row(pal_beat(8'd0, 15'h7FFF), 1'b0, 32'h0));
		dir_rows.push_back(item_row(render_beat(16'h0000, 1'b1), 1'b1, 32'hFFFF_FFFF));
		dir_rows.push_back(item_row(pal_beat(8'd0, 15'h0000), 1'b0, 32'h0));
		dir_rows.push_back(item_row(render_beat(16'h0000, 1'b1), 1'b1, 32'hFF00_0000));
		// tile index above the limit renders as fill
		dir_rows.push_back(item_row(render_beat(16'h03FF, 1'b1), 1'b1, FILL_COLOR_RST));
		dir_rows.push_back(item_row(gfx_beat(15'h7FFF, 8'hFF), 1'b0, 32'h0));
		dir_rows.push_back(item_row(gfx_beat(15'd32, 8'h81), 1'b0, 32'h0));
		dir_rows.push_back(item_row(gfx_beat(15'd33, 8'h42), 1'b0, 32'h0));
		dir_rows.push_back(item_row(gfx_beat(15'd49, 8'hFF), 1'b0, 32'h0));
		dir_rows.push_back(item_row(gfx_beat(15'd63, 8'hA5), 1'b0, 32'h0));
		dir_rows.push_back(item_row(pal_beat(8'd17, 15'h001F), 1'b0, 32'h0));
		dir_rows.push_back(item_row(pal_beat(8'd19, 15'h7C00), 1'b0, 32'h0));
		dir_rows.push_back(item_row(pal_beat(8'd255, 15'h7FFF), 1'b0, 32'h0));
		dir_rows.push_back(item_row(render_beat(16'h0401, 1'b1), 1'b0, 32'h0));
		dir_rows.push_back(item_row(render_beat(16'h4401, 1'b1), 1'b0, 32'h0));
		dir_rows.push_back(item_row(render_beat(16'h8401, 1'b1), 1'b0, 32'h0));
		dir_rows.push_back(item_row(render_beat(16'hE401, 1'b1), 1'b0, 32'h0));
		dir_rows.push_back(cfg_row('{1'b0, 1'b1, TILE_LIMIT_RST, FILL_COLOR_RST}));
		dir_rows.push_back(item_row(render_beat(16'h0401, 1'b0), 1'b1, 32'h0));
		dir_rows.push_back(item_row(render_beat(16'h0000, 1'b1), 1'b1, 32'h0));
		dir_rows.push_back(cfg_row('{1'b1, 1'b1, 11'd0, FILL_COLOR_RST}));
		dir_rows.push_back(item_row(render_beat(16'h0000, 1'b1), 1'b1, 32'h0));
		dir_rows.push_back(cfg_row('{1'b1, 1'b0, 11'd1024, 32'hFFFF_FFFF}));
		dir_rows.push_back(item_row(gfx_beat(15'h3FF0, 8'h5A), 1'b0, 32'h0));
		dir_rows.push_back(item_row(pal_beat(8'd29, 15'h7FFF), 1'b0, 32'h0));
		dir_rows.push_back(item_row(render_beat(16'hFFFF, 1'b1), 1'b0, 32'h0));
		dir_rows.push_back(item_row(render_beat(16'h0000, 1'b0), 1'b1, 32'hFFFF_FFFF));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				wait_idle();
				apply_cfg(dir_rows[i].cfg);
			end else begin
				if (dir_rows[i].beat.cmd == CMD_RENDER)
					prepare_tile(dir_rows[i].beat.entry, dir_rows[i].beat.vis, 1'b0);
				send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].argb);
			end
		end

		phase = 0;
		while (sent_items < ITEM_BUDGET) begin
			wait_idle();
			apply_cfg(pick_cfg(phase));
			phase++;
			burst = $urandom_range(8, 20);
			for (int k = 0; k < burst && sent_items < ITEM_BUDGET; k++) begin
				roll = $urandom_range(0, 99);
				if (roll < 50) begin
					entry = 16'($urandom);
					if (used_tiles.size() > 0 && $urandom_range(0, 99) < 85)
						entry[9:0] = used_tiles[$urandom_range(0, used_tiles.size() - 1)];
					vis = ($urandom_range(0, 99) < 85);
					prepare_tile(entry, vis, 1'b1);
					send_beat(render_beat(entry, vis), 1'b0, 32'h0);
				end else if (roll < 75) begin
					addr = 15'($urandom);
					if (used_tiles.size() > 0 && $urandom_range(0, 1) == 1)
						addr = tile_base(used_tiles[$urandom_range(0, used_tiles.size() - 1)])
							+ 15'($urandom_range(0, 31));
					send_beat(gfx_beat(addr, 8'($urandom)), 1'b0, 32'h0);
				end else if (roll < 93) begin
					send_beat(pal_beat(8'($urandom), 15'($urandom)), 1'b0, 32'h0);
				end else begin
					send_beat(noise_beat(), 1'b0, 32'h0);
				end
			end
		end

		wait_idle();
		if (mismatches == 0 && pending_pixels.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
